// File: rtl/core/trapezoidal_speed_profile_gen_assert.svh
// Assertion macros for the trapezoidal speed profile generator.
`ifndef TRAPEZOIDAL_SPEED_PROFILE_GEN_ASSERT_SVH
`define TRAPEZOIDAL_SPEED_PROFILE_GEN_ASSERT_SVH
`ifndef SYNTH
`define TSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("speed profile assertion failed");
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("speed profile assertion failed");
`else
`define TSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/tsp_pkg.sv
// Package with widths, codes and types of the trapezoidal speed profile generator.
`timescale 1ns / 1ps
package tsp_pkg;

    localparam int SPD_W      = 16;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int SQ_W       = 34;
    localparam int ROOT_W     = 17;
    localparam int REM_W      = 19;
    localparam int ACC_W      = 21;
    localparam int CNT_W      = 5;
    localparam int RATE_SHIFT = 9;

    localparam logic [SPD_W-1:0] SPEED_CEIL_RST = 16'd512;
    localparam logic [SPD_W-1:0] END_SPEED_RST  = 16'd154;
    localparam logic [SPD_W-1:0] ACCEL_RATE_RST = 16'd256;
    localparam logic [SPD_W-1:0] DECEL_RATE_RST = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_CEIL = 2'd0,
        CFG_END_SPEED  = 2'd1,
        CFG_ACCEL_RATE = 2'd2,
        CFG_DECEL_RATE = 2'd3
    } tsp_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_UPDATE,
        ST_SET_END,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_OUT
    } tsp_state_t;

    typedef enum logic [1:0] {
        PASS_FWD_CAP,
        PASS_BWD,
        PASS_FWD
    } tsp_pass_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tsp_root_status_t;

endpackage

// File: rtl/core/tsp_req_if.sv
// Request channel interface carrying the path length.
`timescale 1ns / 1ps
interface tsp_req_if
    import tsp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] path_length;

    modport source (output valid, output path_length, input ready);
    modport sink (input valid, input path_length, output ready);
endinterface

// File: rtl/core/tsp_res_if.sv
// Result channel interface carrying one profile point.
`timescale 1ns / 1ps
interface tsp_res_if
    import tsp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SPD_W-1:0] speed;
    logic [IDX_W-1:0] point_index;
    logic             last;

    modport source (output valid, output speed, output point_index, output last, input ready);
    modport sink (input valid, input speed, input point_index, input last, output ready);
endinterface

// File: rtl/core/trapezoidal_speed_profile_gen.sv
// Trapezoidal speed profile generator: three passes over a profile memory, then emission.
// Each profile point in each pass waits on the 17-step square root unit.
// The first result is offered once all three passes are done for the accepted request.
// Results then leave one at a time, the next only after the sink took the last; the next request waits.
// Reset clears the sequencer and loads the register defaults; the memory is not cleared.
`timescale 1ns / 1ps
`include "trapezoidal_speed_profile_gen_assert.svh"
module trapezoidal_speed_profile_gen
    import tsp_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SPD_W-1:0]     cfg_data,
    tsp_req_if.sink              req,
    tsp_res_if.source            res
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam logic [AW-1:0] LAST_MAX = AW'(MAX_POINTS - 1);

    logic [SPD_W-1:0] speed_ceil_reg;
    logic [SPD_W-1:0] end_speed_reg;
    logic [SPD_W-1:0] accel_rate_reg;
    logic [SPD_W-1:0] decel_rate_reg;

    tsp_state_t        state_reg, state_next;
    tsp_pass_t         pass_reg, pass_next;
    logic [AW-1:0]     last_idx_reg, last_idx_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [SPD_W-1:0]  cur_reg, cur_next;
    logic [2*SPD_W-1:0] sq_reg, sq_next;
    logic              out_valid_reg, out_valid_next;
    logic [SPD_W-1:0]  out_speed_reg, out_speed_next;
    logic [AW-1:0]     out_idx_reg, out_idx_next;
    logic              out_last_reg, out_last_next;

    logic [AW-1:0]     len_last;
    logic [AW-1:0]     step_addr;
    logic [SPD_W-1:0]  rate_sel;
    logic [SPD_W-1:0]  bound;
    logic [SPD_W-1:0]  new_val;
    logic [SQ_W-1:0]   root_operand;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [SPD_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [SPD_W-1:0]  ram_rd_data;

    logic              root_start;
    tsp_root_status_t  root_status;
    logic [SPD_W-1:0]  root_val;

    tsp_ram #(
        .WIDTH (SPD_W),
        .DEPTH (MAX_POINTS)
    ) u_profile_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .re      (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rd_data)
    );

    tsp_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (root_start),
        .operand (root_operand),
        .status  (root_status),
        .root    (root_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_ceil_reg <= SPEED_CEIL_RST;
            end_speed_reg  <= END_SPEED_RST;
            accel_rate_reg <= ACCEL_RATE_RST;
            decel_rate_reg <= DECEL_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (tsp_cfg_idx_t'(cfg_index))
                CFG_SPEED_CEIL: speed_ceil_reg <= cfg_data;
                CFG_END_SPEED:  end_speed_reg  <= cfg_data;
                CFG_ACCEL_RATE: accel_rate_reg <= cfg_data;
                CFG_DECEL_RATE: decel_rate_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (req.path_length == '0)
        begin
            len_last = '0;
        end
        else if (req.path_length > LEN_W'(MAX_POINTS))
        begin
            len_last = LAST_MAX;
        end
        else
        begin
            len_last = AW'(req.path_length - LEN_W'(1));
        end
    end

    assign step_addr    = (pass_reg == PASS_BWD) ? (i_reg - AW'(1)) : i_reg;
    assign rate_sel     = (pass_reg == PASS_BWD) ? decel_rate_reg : accel_rate_reg;
    assign root_operand = SQ_W'(sq_reg) + (SQ_W'(rate_sel) << RATE_SHIFT);
    assign bound        = (pass_reg == PASS_FWD_CAP) ? speed_ceil_reg : ram_rd_data;
    assign new_val      = (root_val < bound) ? root_val : bound;

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        last_idx_next  = last_idx_reg;
        i_next         = i_reg;
        cur_next       = cur_reg;
        sq_next        = sq_reg;
        out_valid_next = out_valid_reg;
        out_speed_next = out_speed_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = step_addr;
        ram_wdata      = new_val;
        ram_re         = 1'b0;
        ram_raddr      = step_addr;
        root_start     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    last_idx_next = len_last;
                    state_next    = ST_INIT;
                end
            end
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '0;
                cur_next  = '0;
                i_next    = AW'(1);
                pass_next = PASS_FWD_CAP;
                state_next = (last_idx_reg == '0) ? ST_SET_END : ST_SQUARE;
            end
            ST_SQUARE:
            begin
                sq_next    = (2*SPD_W)'(cur_reg) * (2*SPD_W)'(cur_reg);
                ram_re     = 1'b1;
                state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (root_status.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ram_we   = 1'b1;
                cur_next = new_val;
                if (pass_reg == PASS_BWD)
                begin
                    if (i_reg == AW'(1))
                    begin
                        pass_next  = PASS_FWD;
                        state_next = ST_SQUARE;
                    end
                    else
                    begin
                        i_next     = i_reg - AW'(1);
                        state_next = ST_SQUARE;
                    end
                end
                else if (i_reg == last_idx_reg)
                begin
                    if (pass_reg == PASS_FWD_CAP)
                    begin
                        state_next = ST_SET_END;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = ST_EMIT_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = ST_SQUARE;
                end
            end
            ST_SET_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = last_idx_reg;
                ram_wdata = end_speed_reg;
                cur_next  = end_speed_reg;
                if (last_idx_reg == '0)
                begin
                    i_next     = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    pass_next  = PASS_BWD;
                    i_next     = last_idx_reg;
                    state_next = ST_SQUARE;
                end
            end
            ST_EMIT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = i_reg;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_speed_next = ram_rd_data;
                out_idx_next   = i_reg;
                out_last_next  = (i_reg == last_idx_reg);
                state_next     = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (res.ready)
                begin
                    out_valid_next = 1'b0;
                    if (i_reg == last_idx_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + AW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= PASS_FWD_CAP;
            last_idx_reg  <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            last_idx_reg  <= last_idx_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        sq_reg        <= sq_next;
        out_speed_reg <= out_speed_next;
        out_idx_reg   <= out_idx_next;
        out_last_reg  <= out_last_next;
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.speed       = out_speed_reg;
    assign res.point_index = IDX_W'(out_idx_reg);
    assign res.last        = out_last_reg;

    // A new transaction is never taken while a result is still on offer.
    `TSP_ASSERT_IMPLY(a_no_req_while_res, clk, rst_n, req.valid && req.ready, !res.valid)
    // The square root unit only runs while the sequencer waits for it.
    `TSP_ASSERT_IMPLY(a_root_busy_wait, clk, rst_n, root_status.busy, state_reg == ST_ROOT_WAIT)
    // Delivering the final point returns the sequencer to idle.
    `TSP_ASSERT_NEXT(a_last_to_idle, clk, rst_n, res.valid && res.ready && res.last,
                     state_reg == ST_IDLE)

endmodule

// File: rtl/core/tsp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module tsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/tsp_sqrt.sv
// Iterative integer square root, two operand bits per cycle, saturated to 16 bits.
`timescale 1ns / 1ps
module tsp_sqrt
    import tsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SQ_W-1:0]  operand,
    output tsp_root_status_t status,
    output logic [SPD_W-1:0] root
);

    logic [SQ_W-1:0]   op_reg, op_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  trial;
    logic [ACC_W-1:0]  diff;

    always_comb
    begin
        acc       = {rem_reg, op_reg[SQ_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        diff      = acc - trial;
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            op_next   = operand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            op_next  = op_reg << 2;
            cnt_next = cnt_reg - 1'b1;
            if (acc >= trial)
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = acc[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg[ROOT_W-1] ? {SPD_W{1'b1}} : root_reg[SPD_W-1:0];

endmodule
